FILE: design/rolling_code_ook_frame_transmitter_core_macros.svh
// Assertion macros used by the checker file.
`ifndef ROLLING_CODE_OOK_FRAME_TRANSMITTER_CORE_MACROS_SVH
`define ROLLING_CODE_OOK_FRAME_TRANSMITTER_CORE_MACROS_SVH

// Same-cycle implication, disabled in reset
`define RCOFT_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rcoft assertion failed");

// Next-cycle implication, disabled in reset
`define RCOFT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rcoft assertion failed");

`endif

FILE: design/rcoft_pkg.sv
`default_nettype none

package rcoft_pkg;

   // Fixed frame layout
   localparam int FRAME_BYTES = 7;
   localparam int FRAME_BITS  = FRAME_BYTES * 8;

   // Transmission shape
   localparam logic [3:0]  TOTAL_FRAMES      = 4'd4;
   localparam logic [5:0]  FIRST_SYNC_PAIRS  = 6'd2;   // first-frame count of sync pairs
   localparam logic [5:0]  REPEAT_SYNC_PAIRS = 6'd7;
   localparam logic [15:0] SW_SYNC_LOW_TICKS = 16'd604;
   localparam logic [5:0]  LAST_BIT          = 6'(FRAME_BITS - 1);

   // Configuration reset values
   localparam logic [3:0]  KEY_RESET       = 4'd7;
   localparam logic [15:0] HALF_SYM_RESET  = 16'd640;
   localparam logic [15:0] GAP_RESET       = 16'd30415;
   localparam logic [15:0] HW_SYNC_RESET   = 16'd2416;
   localparam logic [15:0] SW_HIGH_RESET   = 16'd4550;

   typedef enum logic [2:0] {
      PH_IDLE   = 3'd0,
      PH_HWSYNC = 3'd1,
      PH_SWSYNC = 3'd2,
      PH_DATA   = 3'd3,
      PH_GAP    = 3'd4
   } phase_type;

   typedef enum logic [2:0] {
      ST_TICK     = 3'd0,
      ST_ACCEPTED = 3'd1,
      ST_NOT_EN   = 3'd2,
      ST_NO_ADDR  = 3'd3,
      ST_BUSY     = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      CSR_ADDRESS   = 3'd0,
      CSR_KEY       = 3'd1,
      CSR_ROLL      = 3'd2,
      CSR_ENABLE    = 3'd3,
      CSR_HALF_SYM  = 3'd4,
      CSR_GAP       = 3'd5,
      CSR_HW_SYNC   = 3'd6,
      CSR_SW_HIGH   = 3'd7
   } csr_index_type;

   typedef enum logic {
      FUNC_TICK = 1'b0,
      FUNC_SEND = 1'b1
   } func_type;

   // Build the obfuscated frame, byte 0 in the top bits
   function automatic logic [FRAME_BITS-1:0] build_frame(
      input logic [3:0]  key,
      input logic [3:0]  cmd,
      input logic [15:0] rc,
      input logic [23:0] addr
   );
      logic [7:0] b [FRAME_BYTES];
      logic [3:0] chk;
      b[0] = {key, 4'h0};
      b[2] = rc[15:8];
      b[3] = rc[7:0];
      b[4] = addr[7:0];
      b[5] = addr[15:8];
      b[6] = addr[23:16];
      // XOR of every nibble in the frame
      chk = key ^ cmd ^ rc[15:12] ^ rc[11:8] ^ rc[7:4] ^ rc[3:0]
          ^ addr[23:20] ^ addr[19:16] ^ addr[15:12] ^ addr[11:8]
          ^ addr[7:4] ^ addr[3:0];
      b[1] = {cmd, chk};
      // chain each byte with the obfuscated one before it
      for (int i = 1; i < FRAME_BYTES; i++) begin
         b[i] = b[i] ^ b[i-1];
      end
      return {b[0], b[1], b[2], b[3], b[4], b[5], b[6]};
   endfunction

endpackage

`default_nettype wire

FILE: design/rolling_code_ook_frame_transmitter_core.sv
// A result is valid in the cycle after its request is accepted.
// Throughput: one request or tick per cycle unless the result channel stalls;
// the waveform state and the result register both update on the accepting edge,
// and a waiting result is replaced in the same cycle it is taken.
// Reset (synchronous, active high): idle, line low, rolling code zero,
// configuration back to defaults, no result pending.
`default_nettype none

module rolling_code_ook_frame_transmitter_core
   import rcoft_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_func,
   input  wire logic [3:0]  req_command_code,
   // result channel
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_line_level,
   output logic             rsp_busy_res,
   output logic [2:0]       rsp_request_status,
   output logic             rsp_finished,
   output logic [15:0]      rsp_rolling_code_now,
   output logic [55:0]      rsp_frame_word,
   // configuration
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [23:0] csr_wdata
);

   // Configuration registers
   logic [23:0] address_ff;
   logic [3:0]  key_ff;
   logic        enable_ff;
   logic [15:0] half_sym_ff;
   logic [15:0] gap_ff;
   logic [15:0] hw_sync_ff;
   logic [15:0] sw_high_ff;

   // Waveform state
   logic [15:0]           rolling_ff,  rolling_in;
   logic [FRAME_BITS-1:0] frame_ff,    frame_in;
   phase_type             phase_ff,    phase_in;
   logic [3:0]            frames_ff,   frames_in;
   logic [5:0]            pulses_ff,   pulses_in;
   logic [5:0]            bit_ff,      bit_in;
   logic [15:0]           tick_ff,     tick_in;
   logic                  line_ff,     line_in;

   // Result register
   logic                  rsp_valid_ff;
   logic                  rsp_line_ff;
   logic                  rsp_busy_ff;
   logic [2:0]            rsp_status_ff;
   logic                  rsp_fin_ff;
   logic [15:0]           rsp_roll_ff;
   logic [FRAME_BITS-1:0] rsp_word_ff;

   logic                  accept;
   status_type            status;
   logic                  fin;
   logic [FRAME_BITS-1:0] word;
   logic [15:0]           tick_sum;
   logic [15:0]           seg_len;
   logic [5:0]            pulse_sum;
   logic [5:0]            sync_pairs;
   logic [3:0]            frame_sum;
   logic [5:0]            bit_sum;
   logic                  cur_bit;
   logic                  next_bit;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   // Helper values from current state
   assign tick_sum   = tick_ff + 16'd1;
   assign pulse_sum  = pulses_ff + 6'd1;
   assign frame_sum  = frames_ff + 4'd1;
   assign bit_sum    = bit_ff + 6'd1;
   assign sync_pairs = (frames_ff == 4'd0) ? FIRST_SYNC_PAIRS : REPEAT_SYNC_PAIRS;
   assign cur_bit    = frame_ff[LAST_BIT - bit_ff];
   assign next_bit   = frame_ff[LAST_BIT - bit_sum];

   // Length of the segment in progress
   always_comb begin
      unique case (phase_ff)
         PH_HWSYNC: seg_len = hw_sync_ff;
         PH_SWSYNC: seg_len = line_ff ? sw_high_ff : SW_SYNC_LOW_TICKS;
         PH_DATA:   seg_len = half_sym_ff;
         default:   seg_len = gap_ff;
      endcase
   end

   // Next state and result for one transaction
   always_comb begin
      rolling_in = rolling_ff;
      frame_in   = frame_ff;
      phase_in   = phase_ff;
      frames_in  = frames_ff;
      pulses_in  = pulses_ff;
      bit_in     = bit_ff;
      tick_in    = tick_ff;
      line_in    = line_ff;
      status     = ST_TICK;
      fin        = 1'b0;
      word       = '0;

      if (accept) begin
         if (req_func == FUNC_SEND) begin
            priority if (!enable_ff) begin
               status = ST_NOT_EN;
            end else if (address_ff == 24'd0) begin
               status = ST_NO_ADDR;
            end else if (phase_ff != PH_IDLE) begin
               status = ST_BUSY;
            end else begin
               status    = ST_ACCEPTED;
               word      = build_frame(key_ff, req_command_code, rolling_ff, address_ff);
               frame_in  = word;
               phase_in  = PH_HWSYNC;
               frames_in = 4'd0;
               pulses_in = 6'd0;
               bit_in    = 6'd0;
               tick_in   = 16'd0;
               line_in   = 1'b1;
            end
         end else if (phase_ff != PH_IDLE) begin
            if (tick_sum >= seg_len) begin
               tick_in = 16'd0;
               // segment done: move to the next one
               unique case (phase_ff)
                  PH_HWSYNC: begin
                     if (line_ff) begin
                        line_in = 1'b0;
                     end else begin
                        pulses_in = pulse_sum;
                        if (pulse_sum >= sync_pairs) begin
                           phase_in = PH_SWSYNC;
                        end
                        line_in = 1'b1;
                     end
                  end
                  PH_SWSYNC: begin
                     if (line_ff) begin
                        line_in = 1'b0;
                     end else begin
                        phase_in = PH_DATA;
                        bit_in   = 6'd0;
                        line_in  = frame_ff[LAST_BIT];
                     end
                  end
                  PH_DATA: begin
                     if (line_ff == cur_bit) begin
                        line_in = ~cur_bit;
                     end else if (bit_ff >= LAST_BIT) begin
                        frames_in = frame_sum;
                        line_in   = 1'b0;
                        if (frame_sum >= TOTAL_FRAMES) begin
                           phase_in   = PH_IDLE;
                           rolling_in = rolling_ff + 16'd1;
                           fin        = 1'b1;
                        end else begin
                           phase_in = PH_GAP;
                        end
                     end else begin
                        bit_in  = bit_sum;
                        line_in = next_bit;
                     end
                  end
                  PH_GAP: begin
                     phase_in  = PH_HWSYNC;
                     pulses_in = 6'd0;
                     line_in   = 1'b1;
                  end
                  default: begin
                     phase_in = PH_IDLE;
                     line_in  = 1'b0;
                  end
               endcase
            end else begin
               tick_in = tick_sum;
            end
         end
      end
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         address_ff  <= 24'd0;
         key_ff      <= KEY_RESET;
         enable_ff   <= 1'b0;
         half_sym_ff <= HALF_SYM_RESET;
         gap_ff      <= GAP_RESET;
         hw_sync_ff  <= HW_SYNC_RESET;
         sw_high_ff  <= SW_HIGH_RESET;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_ADDRESS:  address_ff  <= csr_wdata;
            CSR_KEY:      key_ff      <= csr_wdata[3:0];
            CSR_ROLL:     ;
            CSR_ENABLE:   enable_ff   <= csr_wdata[0];
            CSR_HALF_SYM: half_sym_ff <= csr_wdata[15:0];
            CSR_GAP:      gap_ff      <= csr_wdata[15:0];
            CSR_HW_SYNC:  hw_sync_ff  <= csr_wdata[15:0];
            CSR_SW_HIGH:  sw_high_ff  <= csr_wdata[15:0];
         endcase
      end
   end

   // Waveform state; a rolling code write loads the counter
   always_ff @(posedge clock) begin
      if (reset) begin
         rolling_ff <= 16'd0;
         frame_ff   <= '0;
         phase_ff   <= PH_IDLE;
         frames_ff  <= 4'd0;
         pulses_ff  <= 6'd0;
         bit_ff     <= 6'd0;
         tick_ff    <= 16'd0;
         line_ff    <= 1'b0;
      end else begin
         if (csr_we && csr_index_type'(csr_index) == CSR_ROLL) begin
            rolling_ff <= csr_wdata[15:0];
         end else begin
            rolling_ff <= rolling_in;
         end
         frame_ff  <= frame_in;
         phase_ff  <= phase_in;
         frames_ff <= frames_in;
         pulses_ff <= pulses_in;
         bit_ff    <= bit_in;
         tick_ff   <= tick_in;
         line_ff   <= line_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_ready) begin
         rsp_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_line_ff   <= line_in;
         rsp_busy_ff   <= (phase_in != PH_IDLE);
         rsp_status_ff <= status;
         rsp_fin_ff    <= fin;
         rsp_roll_ff   <= rolling_in;
         rsp_word_ff   <= word;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_line_level       = rsp_line_ff;
   assign rsp_busy_res         = rsp_busy_ff;
   assign rsp_request_status   = rsp_status_ff;
   assign rsp_finished         = rsp_fin_ff;
   assign rsp_rolling_code_now = rsp_roll_ff;
   assign rsp_frame_word       = rsp_word_ff;

endmodule

`default_nettype wire

FILE: design/rcoft_checker.sv
`default_nettype none
`include "rolling_code_ook_frame_transmitter_core_macros.svh"

module rcoft_checker
   import rcoft_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic        rsp_line_level,
   input wire logic        rsp_busy_res,
   input wire logic [2:0]  rsp_request_status,
   input wire logic        rsp_finished,
   input wire logic [15:0] rsp_rolling_code_now,
   input wire logic [55:0] rsp_frame_word
);

   // stalled result holds
   `RCOFT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_frame_word) && $stable(rsp_rolling_code_now))

   // end of last frame leaves the line low and the block idle
   `RCOFT_ASSERT_IMPLY(a_fin_idle, clock, reset, rsp_valid && rsp_finished, !rsp_busy_res && !rsp_line_level)

   // an accepted send starts with the line high
   `RCOFT_ASSERT_IMPLY(a_start_high, clock, reset, rsp_valid && rsp_request_status == ST_ACCEPTED, rsp_busy_res && rsp_line_level)

   // idle line is low
   `RCOFT_ASSERT_IMPLY(a_idle_low, clock, reset, rsp_valid && !rsp_busy_res, !rsp_line_level)

   // frame word only on an accepted send
   `RCOFT_ASSERT_IMPLY(a_word_zero, clock, reset, rsp_valid && rsp_request_status != ST_ACCEPTED, rsp_frame_word == 56'd0)

endmodule

bind rolling_code_ook_frame_transmitter_core rcoft_checker u_rcoft_checker (
   .clock                (clock),
   .reset                (reset),
   .rsp_valid            (rsp_valid),
   .rsp_ready            (rsp_ready),
   .rsp_line_level       (rsp_line_level),
   .rsp_busy_res         (rsp_busy_res),
   .rsp_request_status   (rsp_request_status),
   .rsp_finished         (rsp_finished),
   .rsp_rolling_code_now (rsp_rolling_code_now),
   .rsp_frame_word       (rsp_frame_word)
);

`default_nettype wire

FILE: tb/sv/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import rcoft_pkg::*;

   // Transmission shape, kept independent of the package constants
   localparam int TX_FRAMES    = 4;
   localparam int FIRST_PAIRS  = 2;    // sync pairs in the first frame
   localparam int REPEAT_PAIRS = 7;
   localparam int SW_LOW_TICKS = 604;
   localparam int EPISODES     = 6;

   typedef struct {
      logic        line;
      logic        busy;
      logic [2:0]  status;
      logic        fin;
      logic [15:0] rc;
      logic [55:0] word;
   } snapshot_type;

   // Tracks the transmitter state and the outputs each transaction should give
   class scoreboard_type;
      logic [23:0] addr;
      logic [3:0]  key;
      logic        en;
      logic [15:0] half_sym;
      logic [15:0] gap;
      logic [15:0] hw_sync;
      logic [15:0] sw_high;
      logic [15:0] roll;
      logic [55:0] shift_word;
      phase_type   ph;
      logic [3:0]  frames;
      logic [5:0]  pulses;
      logic [5:0]  bit_idx;
      logic [15:0] ticks;
      logic        line;
      snapshot_type predicted_states[$];
      int mismatches;

      function new();
         addr = '0;
         key = 4'd7;
         en = 1'b0;
         half_sym = 16'd640;
         gap = 16'd30415;
         hw_sync = 16'd2416;
         sw_high = 16'd4550;
         roll = '0;
         shift_word = '0;
         ph = PH_IDLE;
         frames = '0;
         pulses = '0;
         bit_idx = '0;
         ticks = '0;
         line = 1'b0;
         mismatches = 0;
      endfunction

      function void write_reg(csr_index_type idx, logic [23:0] v);
         case (idx)
            CSR_ADDRESS:  addr = v;
            CSR_KEY:      key = v[3:0];
            CSR_ROLL:     roll = v[15:0];
            CSR_ENABLE:   en = v[0];
            CSR_HALF_SYM: half_sym = v[15:0];
            CSR_GAP:      gap = v[15:0];
            CSR_HW_SYNC:  hw_sync = v[15:0];
            CSR_SW_HIGH:  sw_high = v[15:0];
            default: ;
         endcase
      endfunction

      function int pending();
         return predicted_states.size();
      endfunction

      function bit tx_active();
         return ph != PH_IDLE;
      endfunction

      // Nibble checksum, then chain every byte with the scrambled one before it
      function logic [55:0] frame_for(logic [3:0] cmd);
         logic [7:0]  b [7];
         logic [7:0]  sum;
         logic [55:0] w;
         b[0] = {key, 4'h0};
         b[1] = {cmd, 4'h0};
         b[2] = roll[15:8];
         b[3] = roll[7:0];
         b[4] = addr[7:0];
         b[5] = addr[15:8];
         b[6] = addr[23:16];
         sum = '0;
         for (int i = 0; i < 7; i++) sum = sum ^ b[i] ^ (b[i] >> 4);
         b[1][3:0] = sum[3:0];
         for (int i = 1; i < 7; i++) b[i] = b[i] ^ b[i-1];
         w = '0;
         for (int i = 0; i < 7; i++) w = {w[47:0], b[i]};
         return w;
      endfunction

      function logic data_bit(logic [5:0] idx);
         return shift_word[6'd55 - idx];
      endfunction

      function logic [15:0] seg_len();
         case (ph)
            PH_HWSYNC: return hw_sync;
            PH_SWSYNC: return line ? sw_high : 16'(SW_LOW_TICKS);
            PH_DATA:   return half_sym;
            default:   return gap;
         endcase
      endfunction

      // Step to the next waveform segment; true when the last frame ends
      function bit advance();
         logic b;
         case (ph)
            PH_HWSYNC: begin
               if (line) begin
                  line = 1'b0;
               end else begin
                  pulses = pulses + 6'd1;
                  if (pulses >= ((frames == 0) ? FIRST_PAIRS : REPEAT_PAIRS))
                     ph = PH_SWSYNC;
                  line = 1'b1;
               end
               return 1'b0;
            end
            PH_SWSYNC: begin
               if (line) begin
                  line = 1'b0;
               end else begin
                  ph = PH_DATA;
                  bit_idx = '0;
                  line = data_bit(6'd0);
               end
               return 1'b0;
            end
            PH_DATA: begin
               b = data_bit(bit_idx);
               // first half done, flip to the second half
               if (line == b) begin
                  line = ~b;
                  return 1'b0;
               end
               if (bit_idx >= 6'd55) begin
                  frames = frames + 4'd1;
                  line = 1'b0;
                  if (frames >= TX_FRAMES) begin
                     ph = PH_IDLE;
                     roll = roll + 16'd1;
                     return 1'b1;
                  end
                  ph = PH_GAP;
                  return 1'b0;
               end
               bit_idx = bit_idx + 6'd1;
               line = data_bit(bit_idx);
               return 1'b0;
            end
            PH_GAP: begin
               ph = PH_HWSYNC;
               pulses = '0;
               line = 1'b1;
               return 1'b0;
            end
            default: begin
               ph = PH_IDLE;
               line = 1'b0;
               return 1'b0;
            end
         endcase
      endfunction

      function void note_request(logic func, logic [3:0] cmd);
         snapshot_type e;
         logic [2:0]  st;
         logic        fin;
         logic [55:0] word;
         st = ST_TICK;
         fin = 1'b0;
         word = '0;
         if (func == FUNC_SEND) begin
            if (!en) st = ST_NOT_EN;
            else if (addr == 0) st = ST_NO_ADDR;
            else if (ph != PH_IDLE) st = ST_BUSY;
            else begin
               st = ST_ACCEPTED;
               word = frame_for(cmd);
               shift_word = word;
               ph = PH_HWSYNC;
               frames = '0;
               pulses = '0;
               bit_idx = '0;
               ticks = '0;
               line = 1'b1;
            end
         end else if (ph != PH_IDLE) begin
            ticks = ticks + 16'd1;
            if (ticks >= seg_len()) begin
               ticks = '0;
               fin = advance();
            end
         end
         e = '{line, ph != PH_IDLE, st, fin, roll, word};
         predicted_states.push_back(e);
      endfunction

      function void check_response(snapshot_type got);
         snapshot_type want;
         if (predicted_states.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: line=%0b busy=%0b status=%0d fin=%0b code=%h frame=%h",
                        got.line, got.busy, got.status, got.fin, got.rc, got.word);
            return;
         end
         want = predicted_states.pop_front();
         if (got.line !== want.line || got.busy !== want.busy || got.status !== want.status ||
             got.fin !== want.fin || got.rc !== want.rc || got.word !== want.word) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("mismatch at %0t:", $realtime);
               $display("  expected line=%0b busy=%0b status=%0d fin=%0b code=%h frame=%h",
                        want.line, want.busy, want.status, want.fin, want.rc, want.word);
               $display("  actual   line=%0b busy=%0b status=%0d fin=%0b code=%h frame=%h",
                        got.line, got.busy, got.status, got.fin, got.rc, got.word);
            end
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_func = 1'b0;
   logic [3:0]  req_command_code = 4'h0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_line_level;
   logic        rsp_busy_res;
   logic [2:0]  rsp_request_status;
   logic        rsp_finished;
   logic [15:0] rsp_rolling_code_now;
   logic [55:0] rsp_frame_word;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = 3'd0;
   logic [23:0] csr_wdata = 24'h0;

   scoreboard_type sb;
   int gap_odds = 20;     // percent chance of a sender gap before a transaction
   int stall_odds = 20;   // percent chance of a receiver stall per cycle

   rolling_code_ook_frame_transmitter_core dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_func             (req_func),
      .req_command_code     (req_command_code),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_line_level       (rsp_line_level),
      .rsp_busy_res         (rsp_busy_res),
      .rsp_request_status   (rsp_request_status),
      .rsp_finished         (rsp_finished),
      .rsp_rolling_code_now (rsp_rolling_code_now),
      .rsp_frame_word       (rsp_frame_word),
      .csr_we               (csr_we),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Receiver: random stall bursts
   initial begin
      forever begin
         @(negedge clock);
         if (stall_odds != 0 && $urandom_range(1, 100) <= stall_odds) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   // Check every result transaction against the oldest prediction
   always @(posedge clock) begin : rsp_monitor
      snapshot_type got;
      if (reset === 1'b0 && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         got = '{rsp_line_level, rsp_busy_res, rsp_request_status, rsp_finished,
                 rsp_rolling_code_now, rsp_frame_word};
         sb.check_response(got);
      end
   end

   // One request transaction; valid stays up across back-to-back items
   task automatic push_item(func_type f, logic [3:0] cmd);
      @(negedge clock);
      if (gap_odds != 0 && $urandom_range(1, 100) <= gap_odds) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_func <= f;
      req_command_code <= cmd;
      do @(posedge clock); while (req_ready !== 1'b1);
      sb.note_request(f, cmd);
   endtask

   task automatic pause_sender();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   task automatic wait_drain();
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [23:0] v);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      sb.write_reg(idx, v);
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // Short timing value, zero included; upper bits are don't-care noise
   function automatic logic [23:0] short_ticks();
      logic [23:0] v;
      v = 24'($urandom());
      v[15:0] = 16'($urandom_range(0, 2));
      return v;
   endfunction

   // A given number of items, ticks with sends mixed in, and at most one drained
   // pause where registers change mid-flight
   task automatic run_items(int count, int pause_at, int send_permille, bit fixed_retune);
      csr_index_type idx;
      for (int n = 0; n < count; n++) begin
         if (n == pause_at) begin
            pause_sender();
            wait_drain();
            if (fixed_retune) begin
               write_reg(CSR_HW_SYNC, 24'h000000);
               write_reg(CSR_KEY, 24'h000005);
               write_reg(CSR_ADDRESS, 24'h123456);
               write_reg(CSR_ROLL, 24'h001234);
            end else begin
               idx = csr_index_type'(3'($urandom_range(0, 7)));
               if (idx >= CSR_HALF_SYM) write_reg(idx, short_ticks());
               else write_reg(idx, 24'($urandom()));
            end
         end
         if ($urandom_range(1, 1000) <= send_permille) push_item(FUNC_SEND, 4'($urandom()));
         else push_item(FUNC_TICK, 4'($urandom()));
      end
   endtask

   initial begin
      logic [23:0] v;
      sb = new();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: rejected while disabled, tick while idle
      push_item(FUNC_SEND, 4'hF);
      push_item(FUNC_TICK, 4'hA);
      pause_sender();
      wait_drain();
      write_reg(CSR_ENABLE, 24'hFFFFF1);
      // enabled but no address
      push_item(FUNC_SEND, 4'h5);
      pause_sender();
      wait_drain();

      // All-ones frame fields, zero timing acting as one tick, longer sync pulse
      write_reg(CSR_ADDRESS, 24'hFFFFFF);
      write_reg(CSR_KEY, 24'h00000F);
      write_reg(CSR_ROLL, 24'h00FFFF);
      write_reg(CSR_HALF_SYM, 24'h000000);
      write_reg(CSR_GAP, 24'hFF0000);
      write_reg(CSR_HW_SYNC, 24'h00000C);
      write_reg(CSR_SW_HIGH, 24'h000000);
      push_item(FUNC_SEND, 4'hF);
      push_item(FUNC_SEND, 4'h0);
      // cut the sync half in progress short; key, address and code change mid-flight
      run_items(40, 6, 20, 1'b1);

      // Random episodes: new settings each time, rejects mixed in
      repeat (EPISODES) begin
         pause_sender();
         wait_drain();
         gap_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 30);
         stall_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 30);
         v = 24'($urandom_range(1, 24'hFFFFFF));
         if ($urandom_range(0, 4) == 0) v = 24'h0;
         write_reg(CSR_ADDRESS, v);
         write_reg(CSR_KEY, 24'($urandom()));
         write_reg(CSR_ROLL, 24'($urandom()));
         v = 24'($urandom()) & ~24'h1;
         if ($urandom_range(0, 4) != 0) v[0] = 1'b1;
         write_reg(CSR_ENABLE, v);
         write_reg(CSR_HALF_SYM, short_ticks());
         write_reg(CSR_GAP, short_ticks());
         write_reg(CSR_HW_SYNC, short_ticks());
         write_reg(CSR_SW_HIGH, short_ticks());
         run_items(150, $urandom_range(1, 149), 60, 1'b0);
      end

      // Last part without idling
      pause_sender();
      wait_drain();
      gap_odds = 0;
      stall_odds = 0;
      write_reg(CSR_ENABLE, 24'h000001);
      write_reg(CSR_ADDRESS, 24'($urandom_range(1, 24'hFFFFFF)));
      write_reg(CSR_HALF_SYM, 24'h000001);
      write_reg(CSR_HW_SYNC, 24'h000001);
      write_reg(CSR_SW_HIGH, 24'h000001);
      write_reg(CSR_GAP, 24'h000001);
      run_items(120, -1, 20, 1'b0);

      pause_sender();
      wait_drain();
      repeat (4) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // Run limit
   initial begin
      #2ms;
      $display("== FAIL ==");
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+design
design/rcoft_pkg.sv
design/rolling_code_ook_frame_transmitter_core.sv
design/rcoft_checker.sv
tb/sv/testbench.sv
